/* sv/rkd_pkg.sv */
// ----------------------------------------------------------------------------
// rkd_pkg
// Shared types and constants for the RSA key DER encoder.
// ----------------------------------------------------------------------------
package rkd_pkg;

  localparam int unsigned ValW     = 64;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned ValBytes = ValW / ByteW;
  localparam int unsigned CntW     = $clog2(ValBytes + 1);
  localparam int unsigned MaxWords = 50;
  localparam int unsigned WcntW    = $clog2(MaxWords + 1);
  localparam int unsigned LenW     = 7;
  localparam int unsigned SlotW    = 4;
  localparam int unsigned ZeroInts = 5;

  localparam logic [ByteW-1:0] TagSeq  = 8'h30;
  localparam logic [ByteW-1:0] TagInt  = 8'h02;
  localparam logic [ByteW-1:0] ZeroByt = 8'h00;

  // fixed content bytes besides the variable value bytes
  // public: two tag/len pairs; private: version int (3), three tag/len pairs,
  // and the zero INTEGERs (3 bytes each)
  localparam logic [LenW-1:0] PubOvh  = LenW'(4);
  localparam logic [LenW-1:0] PrivOvh = LenW'(3 + 3 * 2 + ZeroInts * 3);

  localparam logic [SlotW-1:0] PubLastSlot  = SlotW'(1);
  localparam logic [SlotW-1:0] PrivLastSlot = SlotW'(3 + ZeroInts);

  typedef enum logic [1:0] {
    SRC_ZERO,
    SRC_N,
    SRC_E,
    SRC_D
  } src_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NORM,
    ST_HDR_TAG,
    ST_HDR_LEN,
    ST_INT_TAG,
    ST_INT_LEN,
    ST_INT_PAD,
    ST_INT_DATA
  } state_e;

  typedef struct packed {
    logic            busy;
    logic [CntW-1:0] cnt;   // significant bytes left
    logic            pad;   // leading 0x00 needed (top bit set, or value zero)
  } norm_st_t;

  function automatic src_e slot_src(input logic priv, input logic [SlotW-1:0] idx);
    src_e src;
    src = SRC_ZERO;
    if (!priv) begin
      src = (idx == '0) ? SRC_N : SRC_E;
    end else begin
      unique case (idx)
        SlotW'(0): src = SRC_ZERO;
        SlotW'(1): src = SRC_N;
        SlotW'(2): src = SRC_E;
        SlotW'(3): src = SRC_D;
        default:   src = SRC_ZERO;
      endcase
    end
    return src;
  endfunction

  function automatic logic [CntW-1:0] int_len(input norm_st_t st);
    return st.cnt + CntW'(st.pad);
  endfunction

endpackage

/* sv/rkd_if.sv */
// ----------------------------------------------------------------------------
// rkd_in_if / rkd_out_if
// Valid/ready channels of the RSA key DER encoder.
// ----------------------------------------------------------------------------
interface rkd_in_if;
  logic                       valid;
  logic                       ready;
  logic                       action;
  logic [rkd_pkg::ValW-1:0]   modulus;
  logic [rkd_pkg::ValW-1:0]   public_exponent;
  logic [rkd_pkg::ValW-1:0]   private_exponent;

  modport source (output valid, action, modulus, public_exponent, private_exponent,
                  input ready);
  modport sink   (input valid, action, modulus, public_exponent, private_exponent,
                  output ready);
endinterface

interface rkd_out_if;
  logic                       valid;
  logic                       ready;
  logic [rkd_pkg::ByteW-1:0]  data_byte;
  logic                       last_byte;

  modport source (output valid, data_byte, last_byte, input ready);
  modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

/* sv/rsa_key_der_encoder.sv */
// ----------------------------------------------------------------------------
// rsa_key_der_encoder
// Streams the DER encoding of an RSA public or private key, one byte a word.
// ----------------------------------------------------------------------------
// Input channel in_i takes one key word: action (0 public, 1 private),
// modulus, public and private exponent. Output channel out_o returns the
// encoding one byte per word, last_byte marking the final one; encodings
// longer than 50 bytes are cut at 50 with last_byte on the 50th.
// After acceptance three byte-serial normalizers strip leading zero bytes,
// one byte per cycle. Then the sequencer emits one byte per cycle into the
// output register whenever that register can take a byte; the normalizer
// scan and the single byte-wide output register limit the key throughput.
// in_i.ready is high only while the sequencer is idle; the last byte of an
// item may still wait in the output register when the next key is taken.
// When out_o.ready is low the output register holds and the sequencer waits.
// Reset clears the sequencer and the output valid; no result is pending.
// ----------------------------------------------------------------------------
module rsa_key_der_encoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  rkd_in_if.sink      in_i,
  rkd_out_if.source   out_o
);

  rkd_pkg::state_e               state_q, state_d;
  logic                          action_q, action_d;
  logic [rkd_pkg::SlotW-1:0]     slot_q, slot_d;
  logic [rkd_pkg::CntW-1:0]      rem_q, rem_d;
  logic [rkd_pkg::WcntW-1:0]     wcnt_q, wcnt_d;
  logic                          out_valid_q, out_valid_d;
  logic [rkd_pkg::ByteW-1:0]     data_q, data_d;
  logic                          last_q, last_d;

  rkd_pkg::norm_st_t             st_n, st_e, st_d;
  logic [rkd_pkg::ByteW-1:0]     byte_n, byte_e, byte_d;
  logic                          start, pop, pop_n, pop_e, pop_d;

  rkd_pkg::src_e                 src;
  rkd_pkg::norm_st_t             sel_st;
  logic [rkd_pkg::ByteW-1:0]     sel_byte;
  logic [rkd_pkg::LenW-1:0]      len_sum;
  logic [rkd_pkg::SlotW-1:0]     last_slot;
  logic                          emit, word, int_end, fin, sat;
  logic [rkd_pkg::ByteW-1:0]     wbyte;

  rkd_norm u_norm_n (
    .clk_i, .rst_ni, .start_i(start), .value_i(in_i.modulus),
    .pop_i(pop_n), .st_o(st_n), .byte_o(byte_n)
  );

  rkd_norm u_norm_e (
    .clk_i, .rst_ni, .start_i(start), .value_i(in_i.public_exponent),
    .pop_i(pop_e), .st_o(st_e), .byte_o(byte_e)
  );

  rkd_norm u_norm_d (
    .clk_i, .rst_ni, .start_i(start), .value_i(in_i.private_exponent),
    .pop_i(pop_d), .st_o(st_d), .byte_o(byte_d)
  );

  assign src = rkd_pkg::slot_src(action_q, slot_q);

  always_comb begin
    case (src)
      rkd_pkg::SRC_N: begin
        sel_st   = st_n;
        sel_byte = byte_n;
      end
      rkd_pkg::SRC_E: begin
        sel_st   = st_e;
        sel_byte = byte_e;
      end
      rkd_pkg::SRC_D: begin
        sel_st   = st_d;
        sel_byte = byte_d;
      end
      default: begin
        sel_st   = '{busy: 1'b0, cnt: '0, pad: 1'b1};
        sel_byte = rkd_pkg::ZeroByt;
      end
    endcase
  end

  always_comb begin
    len_sum = rkd_pkg::LenW'(rkd_pkg::int_len(st_n)) + rkd_pkg::LenW'(rkd_pkg::int_len(st_e));
    if (action_q) begin
      len_sum = len_sum + rkd_pkg::LenW'(rkd_pkg::int_len(st_d)) + rkd_pkg::PrivOvh;
    end else begin
      len_sum = len_sum + rkd_pkg::PubOvh;
    end
  end

  assign last_slot = action_q ? rkd_pkg::PrivLastSlot : rkd_pkg::PubLastSlot;
  assign emit      = !out_valid_q || out_o.ready;
  assign sat       = (wcnt_q == rkd_pkg::WcntW'(rkd_pkg::MaxWords - 1));
  assign pop_n     = pop && (src == rkd_pkg::SRC_N);
  assign pop_e     = pop && (src == rkd_pkg::SRC_E);
  assign pop_d     = pop && (src == rkd_pkg::SRC_D);

  always_comb begin
    state_d     = state_q;
    action_d    = action_q;
    slot_d      = slot_q;
    rem_d       = rem_q;
    wcnt_d      = wcnt_q;
    out_valid_d = out_valid_q && !out_o.ready;
    data_d      = data_q;
    last_d      = last_q;
    start       = 1'b0;
    pop         = 1'b0;
    word        = 1'b0;
    int_end     = 1'b0;
    fin         = 1'b0;
    wbyte       = rkd_pkg::ZeroByt;

    unique case (state_q)
      rkd_pkg::ST_IDLE: begin
        if (in_i.valid) begin
          start    = 1'b1;
          action_d = in_i.action;
          slot_d   = '0;
          wcnt_d   = '0;
          state_d  = rkd_pkg::ST_NORM;
        end
      end
      rkd_pkg::ST_NORM: begin
        if (!(st_n.busy || st_e.busy || st_d.busy)) begin
          state_d = rkd_pkg::ST_HDR_TAG;
        end
      end
      rkd_pkg::ST_HDR_TAG: begin
        if (emit) begin
          word    = 1'b1;
          wbyte   = rkd_pkg::TagSeq;
          state_d = rkd_pkg::ST_HDR_LEN;
        end
      end
      rkd_pkg::ST_HDR_LEN: begin
        if (emit) begin
          word    = 1'b1;
          wbyte   = {1'b0, len_sum};
          state_d = rkd_pkg::ST_INT_TAG;
        end
      end
      rkd_pkg::ST_INT_TAG: begin
        if (emit) begin
          word    = 1'b1;
          wbyte   = rkd_pkg::TagInt;
          state_d = rkd_pkg::ST_INT_LEN;
        end
      end
      rkd_pkg::ST_INT_LEN: begin
        if (emit) begin
          word    = 1'b1;
          wbyte   = rkd_pkg::ByteW'(rkd_pkg::int_len(sel_st));
          rem_d   = sel_st.cnt;
          state_d = sel_st.pad ? rkd_pkg::ST_INT_PAD : rkd_pkg::ST_INT_DATA;
        end
      end
      rkd_pkg::ST_INT_PAD: begin
        if (emit) begin
          word    = 1'b1;
          wbyte   = rkd_pkg::ZeroByt;
          int_end = (rem_q == '0);   // zero value: the pad is the whole body
          state_d = rkd_pkg::ST_INT_DATA;
        end
      end
      rkd_pkg::ST_INT_DATA: begin
        if (emit) begin
          word    = 1'b1;
          wbyte   = sel_byte;
          pop     = 1'b1;
          rem_d   = rem_q - 1'b1;
          int_end = (rem_q == rkd_pkg::CntW'(1));
        end
      end
      default: state_d = rkd_pkg::ST_IDLE;
    endcase

    if (word) begin
      fin         = sat || (int_end && slot_q == last_slot);
      out_valid_d = 1'b1;
      data_d      = wbyte;
      last_d      = fin;
      wcnt_d      = wcnt_q + 1'b1;
      if (fin) begin
        state_d = rkd_pkg::ST_IDLE;
      end else if (int_end) begin
        slot_d  = slot_q + 1'b1;
        state_d = rkd_pkg::ST_INT_TAG;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rkd_pkg::ST_IDLE;
      action_q    <= 1'b0;
      slot_q      <= '0;
      rem_q       <= '0;
      wcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      action_q    <= action_d;
      slot_q      <= slot_d;
      rem_q       <= rem_d;
      wcnt_q      <= wcnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    last_q <= last_d;
  end

  assign in_i.ready      = (state_q == rkd_pkg::ST_IDLE);
  assign out_o.valid     = out_valid_q;
  assign out_o.data_byte = data_q;
  assign out_o.last_byte = last_q;

`ifndef ASSERT_OFF
  a_accept_norm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> state_q == rkd_pkg::ST_NORM)
    else $error("accepted key did not start normalizing");

  a_pop_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_n || pop_e || pop_d) |-> !(st_n.busy || st_e.busy || st_d.busy))
    else $error("byte popped from a normalizer still scanning");

  a_wcnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wcnt_q <= rkd_pkg::WcntW'(rkd_pkg::MaxWords))
    else $error("word count beyond limit");

  a_fin_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (word && fin) |=> (state_q == rkd_pkg::ST_IDLE && out_o.valid && out_o.last_byte))
    else $error("final word did not end the item");
`endif

endmodule

/* sv/rkd_norm.sv */
// ----------------------------------------------------------------------------
// rkd_norm
// Byte-serial normalizer: strips leading zero bytes, then shifts the value
// out MSB byte first.
// ----------------------------------------------------------------------------
module rkd_norm (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [rkd_pkg::ValW-1:0]   value_i,
  input  logic                       pop_i,
  output rkd_pkg::norm_st_t          st_o,
  output logic [rkd_pkg::ByteW-1:0]  byte_o
);

  logic [rkd_pkg::ValW-1:0] sh_q, sh_d;
  logic [rkd_pkg::CntW-1:0] cnt_q, cnt_d;
  logic                     busy_q, busy_d;
  logic [rkd_pkg::ByteW-1:0] top;

  assign top = sh_q[rkd_pkg::ValW-1 -: rkd_pkg::ByteW];

  always_comb begin
    sh_d   = sh_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      sh_d   = value_i;
      cnt_d  = rkd_pkg::CntW'(rkd_pkg::ValBytes);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (cnt_q == '0 || top != '0) begin
        busy_d = 1'b0;
      end else begin
        sh_d  = sh_q << rkd_pkg::ByteW;
        cnt_d = cnt_q - 1'b1;
      end
    end else if (pop_i) begin
      sh_d  = sh_q << rkd_pkg::ByteW;
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q <= sh_d;
  end

  assign st_o.busy = busy_q;
  assign st_o.cnt  = cnt_q;
  assign st_o.pad  = (cnt_q == '0) || top[rkd_pkg::ByteW-1];
  assign byte_o    = top;

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the RSA key DER encoder. A directed table of keys, some rows
// with their byte stream typed in, then random keys over several phases of
// sender idling and receiver stalls. Every output word is checked against
// the typed bytes of its row or else the DER predictor kept in the bench.
// ----------------------------------------------------------------------------
module tb_top;

  localparam logic KeyPub  = 1'b0;
  localparam logic KeyPriv = 1'b1;

  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned DrainCycles   = 80;
  localparam int unsigned RandPerPhase  = 29;
  localparam int unsigned NumRows       = 15;

  typedef struct packed {
    logic [rkd_pkg::ByteW-1:0] data;
    logic                      last;
  } der_word_t;

  typedef struct {
    logic                     priv;
    logic [rkd_pkg::ValW-1:0] n;
    logic [rkd_pkg::ValW-1:0] e;
    logic [rkd_pkg::ValW-1:0] d;
    int                       exp_len;  // 0: predicted
    logic [167:0]             exp;      // typed bytes, first byte leftmost
  } key_row_t;

  key_row_t key_rows [NumRows] = '{
    '{KeyPub, 64'h0, 64'h0, 64'h0, 8, 168'h3006020100020100},
    '{KeyPub, 64'h1, 64'h80, 64'h0, 9, 168'h300702010102020080},
    '{KeyPub, 64'hffff_ffff_ffff_ffff, 64'h0, 64'h0, 16,
      168'h300e020900ffffffffffffffff020100},
    '{KeyPub, 64'h7f, 64'h7fff_ffff_ffff_ffff, 64'h0, 15,
      168'h300d02017f02087fffffffffffffff},
    // d has no effect on a public key
    '{KeyPub, 64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff,
      64'hffff_ffff_ffff_ffff, 0, 168'h0},
    '{KeyPriv, 64'h0, 64'h0, 64'h0, 0, 168'h0},
    // 53 bytes, cut at the word limit
    '{KeyPriv, 64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff,
      64'hffff_ffff_ffff_ffff, 0, 168'h0},
    // exactly at the word limit
    '{KeyPriv, 64'h7fff_ffff_ffff_ffff, 64'h7fff_ffff_ffff_ffff,
      64'h7fff_ffff_ffff_ffff, 0, 168'h0},
    // one over the limit
    '{KeyPriv, 64'h8000_0000_0000_0000, 64'h7fff_ffff_ffff_ffff,
      64'h7fff_ffff_ffff_ffff, 0, 168'h0},
    '{KeyPriv, 64'h80, 64'h10001, 64'hff, 0, 168'h0},
    '{KeyPub, 64'h100, 64'h0080_0000_0000_0000, 64'h0, 0, 168'h0},
    '{KeyPub, 64'h00ff_00ff_00ff_00ff, 64'h10001, 64'h5, 0, 168'h0},
    '{KeyPriv, 64'h0123_4567_89ab_cdef, 64'h3, 64'hfedc_ba98_7654_3210, 0, 168'h0},
    '{KeyPub, 64'h8000_0000_0000_0000, 64'h1, 64'h0, 0, 168'h0},
    '{KeyPriv, 64'h1, 64'h1, 64'h0, 0, 168'h0}
  };

  logic clk;
  logic rst_n;

  rkd_in_if  in_if ();
  rkd_out_if out_if ();

  rsa_key_der_encoder i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  der_word_t                 der_exp_q[$];
  logic [rkd_pkg::ByteW-1:0] key_body[$];
  int unsigned               errors;
  int unsigned               src_idle_pct;
  int unsigned               sink_stall_pct;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic flag_error(input string msg);
    errors++;
    $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  // append one DER INTEGER to the sequence body
  function automatic void put_der_int(input logic [rkd_pkg::ValW-1:0] v);
    int first;
    first = 0;
    while (first < rkd_pkg::ValBytes &&
           v[rkd_pkg::ValW-1-rkd_pkg::ByteW*first -: rkd_pkg::ByteW] == 8'h00) first++;
    key_body.push_back(rkd_pkg::TagInt);
    if (first == rkd_pkg::ValBytes) begin
      key_body.push_back(8'h01);
      key_body.push_back(rkd_pkg::ZeroByt);
    end else begin
      if (v[rkd_pkg::ValW-1-rkd_pkg::ByteW*first]) begin
        key_body.push_back(rkd_pkg::ByteW'(rkd_pkg::ValBytes - first + 1));
        key_body.push_back(rkd_pkg::ZeroByt);
      end else begin
        key_body.push_back(rkd_pkg::ByteW'(rkd_pkg::ValBytes - first));
      end
      for (int k = first; k < rkd_pkg::ValBytes; k++)
        key_body.push_back(v[rkd_pkg::ValW-1-rkd_pkg::ByteW*k -: rkd_pkg::ByteW]);
    end
  endfunction

  function automatic void predict_key(input logic priv, input logic [rkd_pkg::ValW-1:0] n,
                                      input logic [rkd_pkg::ValW-1:0] e,
                                      input logic [rkd_pkg::ValW-1:0] d);
    int total;
    logic [rkd_pkg::ByteW-1:0] b;
    key_body.delete();
    if (!priv) begin
      put_der_int(n);
      put_der_int(e);
    end else begin
      put_der_int('0);
      put_der_int(n);
      put_der_int(e);
      put_der_int(d);
      for (int z = 0; z < rkd_pkg::ZeroInts; z++) put_der_int('0);
    end
    total = key_body.size() + 2;
    if (total > rkd_pkg::MaxWords) total = rkd_pkg::MaxWords;
    for (int i = 0; i < total; i++) begin
      if (i == 0) b = rkd_pkg::TagSeq;
      else if (i == 1) b = {1'b0, 7'(key_body.size())};
      else b = key_body[i-2];
      der_exp_q.push_back('{data: b, last: (i == total - 1)});
    end
  endfunction

  // random value of random significant length, zero and all ones included
  function automatic logic [rkd_pkg::ValW-1:0] rand_key_val();
    logic [rkd_pkg::ValW-1:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(9))
      0:       v = '0;
      1:       v = '1;
      2:       v = v | {1'b1, {(rkd_pkg::ValW-1){1'b0}}};
      default: v = v >> (rkd_pkg::ByteW * $urandom_range(7));
    endcase
    return v;
  endfunction

  task automatic send_key(input logic priv, input logic [rkd_pkg::ValW-1:0] n,
                          input logic [rkd_pkg::ValW-1:0] e,
                          input logic [rkd_pkg::ValW-1:0] d);
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid            <= 1'b1;
    in_if.action           <= priv;
    in_if.modulus          <= n;
    in_if.public_exponent  <= e;
    in_if.private_exponent <= d;
    do @(posedge clk); while (!in_if.ready);
  endtask

  // receiver: check each accepted word against the oldest expectation
  initial begin
    der_word_t want;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_if.valid && out_if.ready) begin
        if (der_exp_q.size() == 0) begin
          flag_error($sformatf("unexpected word data=%h last=%b",
                               out_if.data_byte, out_if.last_byte));
        end else begin
          want = der_exp_q.pop_front();
          if (out_if.data_byte !== want.data)
            flag_error($sformatf("data_byte %h, want %h", out_if.data_byte, want.data));
          if (out_if.last_byte !== want.last)
            flag_error($sformatf("last_byte %b, want %b", out_if.last_byte, want.last));
        end
      end
      out_if.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // watchdog: cycles without any accepted word
  initial begin
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet = 0;
      else quiet++;
      if (quiet >= WatchdogLimit) begin
        $display("tb_top NOT OK");
        $finish;
      end
    end
  end

  initial begin
    logic                     priv;
    logic [rkd_pkg::ValW-1:0] n, e, d;
    errors                 = 0;
    src_idle_pct           = 0;
    sink_stall_pct         = 0;
    rst_n                  <= 1'b0;
    in_if.valid            <= 1'b0;
    in_if.action           <= KeyPub;
    in_if.modulus          <= '0;
    in_if.public_exponent  <= '0;
    in_if.private_exponent <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (key_rows[r]) begin
      send_key(key_rows[r].priv, key_rows[r].n, key_rows[r].e, key_rows[r].d);
      if (key_rows[r].exp_len != 0) begin
        for (int i = 0; i < key_rows[r].exp_len; i++)
          der_exp_q.push_back(
            '{data: key_rows[r].exp[(key_rows[r].exp_len-1-i)*rkd_pkg::ByteW +: rkd_pkg::ByteW],
              last: (i == key_rows[r].exp_len - 1)});
      end else begin
        predict_key(key_rows[r].priv, key_rows[r].n, key_rows[r].e, key_rows[r].d);
      end
    end

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1:       begin src_idle_pct = 81; sink_stall_pct = 0;  end
        2:       begin src_idle_pct = 0;  sink_stall_pct = 81; end
        default: begin src_idle_pct = 24; sink_stall_pct = 24; end
      endcase
      for (int k = 0; k < RandPerPhase; k++) begin
        priv = ($urandom_range(1) == 1) ? KeyPriv : KeyPub;
        n    = rand_key_val();
        e    = rand_key_val();
        d    = rand_key_val();
        send_key(priv, n, e, d);
        predict_key(priv, n, e, d);
      end
    end
    in_if.valid <= 1'b0;
    sink_stall_pct = 0;

    while (der_exp_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/rkd_pkg.sv
sv/rkd_if.sv
sv/rkd_norm.sv
sv/rsa_key_der_encoder.sv
test/tb_top.sv
